// ===== rtl/amct_pkg.sv =====
package amct_pkg;

  // phase codes as seen on the phase output
  typedef enum logic [1:0] {
    PH_OFF  = 2'd0,
    PH_PEND = 2'd1,
    PH_ACT  = 2'd2
  } phase_t;

  // input word kinds
  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_TOUCH   = 2'd1,
    MODE_REQ_ON  = 2'd2,
    MODE_REQ_OFF = 2'd3
  } mode_t;

  // configuration port
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_CORNER_SIZE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAP_WINDOW        = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TAPS_TO_EXIT      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_COUNTDOWN_SECONDS = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_TICKS_PER_SECOND  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_WIDTH      = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCREEN_HEIGHT     = 3'd6;

  // register reset values
  localparam logic [11:0] RST_CORNER_SIZE       = 12'd130;
  localparam logic [15:0] RST_TAP_WINDOW        = 16'd3000;
  localparam logic [2:0]  RST_TAPS_TO_EXIT      = 3'd4;
  localparam logic [7:0]  RST_COUNTDOWN_SECONDS = 8'd10;
  localparam logic [9:0]  RST_TICKS_PER_SECOND  = 10'd1000;
  localparam logic [12:0] RST_SCREEN_WIDTH      = 13'd1024;
  localparam logic [12:0] RST_SCREEN_HEIGHT     = 13'd600;

endpackage

// ===== rtl/away_mode_arm_and_corner_tap_exit_unit.sv =====
// away-mode controller: arm by countdown, leave by a corner-tap gesture
//
// input channel (in_valid / in_stall) carries one word per event: a 1 ms tick,
// a touch with signed x/y, a request on or a request off. every accepted word
// yields exactly one result word on the output channel (out_valid / out_stall)
// with the phase, the seconds left while pending, the tap count and three
// event flags (entered, left, cancelled).
// each result goes into the output register, or into the skid register while
// the output register stalls. throughput: one word per cycle while the skid is
// empty; all state updates are a single pass of compare/add logic at the accept edge.
// the result stage is an output register plus one skid register, so a word is
// still taken while the receiver stalls; in_stall rises only once both hold data.
// a stalled result holds its value until taken.
// configuration is a plain write port (cfg_we, cfg_index, cfg_data); indexes
// beyond the last register are ignored. the user must write it only while the
// block is idle; the block does not enforce this. reset (rst, synchronous):
// phase off, all counters clear, result stage empty, register defaults loaded.
module away_mode_arm_and_corner_tap_exit_unit #(
  parameter int TIME_BITS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [amct_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [amct_pkg::CFG_DATA_W-1:0]        cfg_data,
  // input channel
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             mode,
  input  logic signed [11:0]                     touch_x,
  input  logic signed [11:0]                     touch_y,
  // output channel
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             phase,
  output logic [7:0]                             seconds_left,
  output logic [2:0]                             taps_seen,
  output logic                                   entered_active,
  output logic                                   left_active,
  output logic                                   countdown_cancelled
);

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] seconds_left;
    logic [2:0] taps_seen;
    logic       entered;
    logic       left;
    logic       cancelled;
  } result_t;

  // configuration registers
  logic [11:0] corner_size;
  logic [15:0] tap_window;
  logic [2:0]  taps_to_exit;
  logic [7:0]  countdown_seconds;
  logic [9:0]  ticks_per_second;
  logic [12:0] screen_width;
  logic [12:0] screen_height;

  // controller state
  amct_pkg::phase_t       phase_reg, phase_reg_next;
  logic [7:0]             seconds_count, seconds_count_next;
  logic [9:0]             subsecond_ticks, subsecond_ticks_next;
  logic [TIME_BITS-1:0]   clock_ms, clock_ms_next;
  logic [2:0]             taps_reg, taps_reg_next;
  logic [TIME_BITS-1:0]   first_tap_time, first_tap_time_next;

  // result stage: output register and skid register
  result_t res_next;
  result_t out_word;
  result_t skid_word;
  logic    skid_valid;

  logic in_accept;
  logic out_take;

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;

  // corner test, all signed at 15 bits
  logic signed [14:0] corner_s;
  logic signed [14:0] x_s;
  logic signed [14:0] y_s;
  logic signed [14:0] right_lim;
  logic signed [14:0] bottom_lim;
  logic               corner_hit;

  assign corner_s   = signed'({3'b000, corner_size});
  assign x_s        = 15'(touch_x);
  assign y_s        = 15'(touch_y);
  assign right_lim  = signed'({2'b00, screen_width}) - corner_s;
  assign bottom_lim = signed'({2'b00, screen_height}) - corner_s;
  assign corner_hit = ((x_s < corner_s) || (x_s > right_lim)) &&
                      ((y_s < corner_s) || (y_s > bottom_lim));

  // window age wraps at the clock width
  logic [TIME_BITS-1:0] tap_age;
  logic                 window_expired;

  assign tap_age        = clock_ms - first_tap_time;
  assign window_expired = tap_age > TIME_BITS'(tap_window);

  // one pass of next-state logic per accepted word
  always_comb begin
    logic [9:0] tps;
    logic [9:0] sub_inc;
    logic [2:0] taps_new;

    tps      = (ticks_per_second == 10'd0) ? 10'd1 : ticks_per_second;
    sub_inc  = subsecond_ticks + 10'd1;
    taps_new = 3'd0;

    phase_reg_next       = phase_reg;
    seconds_count_next   = seconds_count;
    subsecond_ticks_next = subsecond_ticks;
    clock_ms_next        = clock_ms;
    taps_reg_next        = taps_reg;
    first_tap_time_next  = first_tap_time;
    res_next.entered     = 1'b0;
    res_next.left        = 1'b0;
    res_next.cancelled   = 1'b0;

    case (amct_pkg::mode_t'(mode))
      amct_pkg::MODE_TICK: begin
        // free-running millisecond clock, advances in every phase
        clock_ms_next = clock_ms + TIME_BITS'(1);
        if (phase_reg == amct_pkg::PH_PEND) begin
          if (sub_inc >= tps) begin
            subsecond_ticks_next = 10'd0;
            if (seconds_count <= 8'd1) begin
              // countdown done: arm
              seconds_count_next = 8'd0;
              phase_reg_next     = amct_pkg::PH_ACT;
              taps_reg_next      = 3'd0;
              res_next.entered   = 1'b1;
            end else begin
              seconds_count_next = seconds_count - 8'd1;
            end
          end else begin
            subsecond_ticks_next = sub_inc;
          end
        end
      end
      amct_pkg::MODE_TOUCH: begin
        if (phase_reg == amct_pkg::PH_ACT && corner_hit) begin
          if (taps_reg == 3'd0 || window_expired) begin
            // open a new window
            taps_new            = 3'd1;
            first_tap_time_next = clock_ms;
          end else begin
            taps_new = taps_reg + 3'd1;
          end
          if (taps_new >= taps_to_exit) begin
            // gesture complete
            taps_reg_next  = 3'd0;
            phase_reg_next = amct_pkg::PH_OFF;
            res_next.left  = 1'b1;
          end else begin
            taps_reg_next = taps_new;
          end
        end
      end
      amct_pkg::MODE_REQ_ON: begin
        if (phase_reg == amct_pkg::PH_OFF) begin
          phase_reg_next       = amct_pkg::PH_PEND;
          seconds_count_next   = countdown_seconds;
          subsecond_ticks_next = 10'd0;
        end
      end
      amct_pkg::MODE_REQ_OFF: begin
        if (phase_reg == amct_pkg::PH_PEND) begin
          phase_reg_next     = amct_pkg::PH_OFF;
          res_next.cancelled = 1'b1;
        end else if (phase_reg == amct_pkg::PH_ACT) begin
          // tap count is kept when leaving by request
          phase_reg_next = amct_pkg::PH_OFF;
          res_next.left  = 1'b1;
        end
      end
      default: begin
      end
    endcase

    res_next.phase        = phase_reg_next;
    res_next.seconds_left = (phase_reg_next == amct_pkg::PH_PEND) ? seconds_count_next : 8'd0;
    res_next.taps_seen    = taps_reg_next;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      corner_size       <= amct_pkg::RST_CORNER_SIZE;
      tap_window        <= amct_pkg::RST_TAP_WINDOW;
      taps_to_exit      <= amct_pkg::RST_TAPS_TO_EXIT;
      countdown_seconds <= amct_pkg::RST_COUNTDOWN_SECONDS;
      ticks_per_second  <= amct_pkg::RST_TICKS_PER_SECOND;
      screen_width      <= amct_pkg::RST_SCREEN_WIDTH;
      screen_height     <= amct_pkg::RST_SCREEN_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        amct_pkg::CFG_CORNER_SIZE:       corner_size       <= cfg_data[11:0];
        amct_pkg::CFG_TAP_WINDOW:        tap_window        <= cfg_data[15:0];
        amct_pkg::CFG_TAPS_TO_EXIT:      taps_to_exit      <= cfg_data[2:0];
        amct_pkg::CFG_COUNTDOWN_SECONDS: countdown_seconds <= cfg_data[7:0];
        amct_pkg::CFG_TICKS_PER_SECOND:  ticks_per_second  <= cfg_data[9:0];
        amct_pkg::CFG_SCREEN_WIDTH:      screen_width      <= cfg_data[12:0];
        amct_pkg::CFG_SCREEN_HEIGHT:     screen_height     <= cfg_data[12:0];
        default: begin
        end
      endcase
    end
  end

  // controller state, updated only on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg       <= amct_pkg::PH_OFF;
      seconds_count   <= 8'd0;
      subsecond_ticks <= 10'd0;
      clock_ms        <= '0;
      taps_reg        <= 3'd0;
      first_tap_time  <= '0;
    end else if (in_accept) begin
      phase_reg       <= phase_reg_next;
      seconds_count   <= seconds_count_next;
      subsecond_ticks <= subsecond_ticks_next;
      clock_ms        <= clock_ms_next;
      taps_reg        <= taps_reg_next;
      first_tap_time  <= first_tap_time_next;
    end
  end

  // result stage control; a word is accepted only with the skid empty
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (out_valid && out_stall) begin
        skid_word <= res_next;
      end else begin
        out_word <= res_next;
      end
    end else if (out_take && skid_valid) begin
      out_word <= skid_word;
    end
  end

  assign phase               = out_word.phase;
  assign seconds_left        = out_word.seconds_left;
  assign taps_seen           = out_word.taps_seen;
  assign entered_active      = out_word.entered;
  assign left_active         = out_word.left;
  assign countdown_cancelled = out_word.cancelled;

endmodule

// ===== rtl/amct_checker.sv =====
module amct_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] phase,
  input logic [7:0] seconds_left,
  input logic [2:0] taps_seen,
  input logic       entered_active,
  input logic       left_active,
  input logic       countdown_cancelled
);

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(seconds_left) &&
      $stable(taps_seen) && $stable(entered_active) && $stable(left_active) &&
      $stable(countdown_cancelled))
    else $error("stalled result word changed");

  // at most one event flag per word
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({entered_active, left_active, countdown_cancelled}))
    else $error("more than one event flag in a word");

  // arming lands in active with a fresh tap count
  a_entered: assert property (@(posedge clk) disable iff (rst)
    out_valid && entered_active |->
      phase == amct_pkg::PH_ACT && taps_seen == 3'd0 && seconds_left == 8'd0)
    else $error("entered flag without active phase");

  // leaving or cancelling always ends in off
  a_to_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && (left_active || countdown_cancelled) |->
      phase == amct_pkg::PH_OFF && seconds_left == 8'd0)
    else $error("leave or cancel flag without off phase");

  // seconds left shows only while pending
  a_seconds: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != amct_pkg::PH_PEND |-> seconds_left == 8'd0)
    else $error("seconds left outside pending phase");

endmodule

bind away_mode_arm_and_corner_tap_exit_unit amct_checker u_amct_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side

  // one status word as it leaves the block
  typedef struct packed {
    amct_pkg::phase_t ph;
    logic [7:0]       secs;
    logic [2:0]       taps;
    logic             entered;
    logic             left_act;
    logic             cancelled;
  } status_t;

  typedef struct {
    logic [11:0] corner;
    logic [15:0] window;
    logic [2:0]  taps_exit;
    logic [7:0]  cd_secs;
    logic [9:0]  tps;
    logic [12:0] width;
    logic [12:0] height;
  } regs_t;

  // one line of the directed plan: a register write or an input word
  typedef struct {
    bit                                 is_cfg;
    logic [amct_pkg::CFG_INDEX_W-1:0]   idx;
    logic [amct_pkg::CFG_DATA_W-1:0]    data;
    amct_pkg::mode_t                    m;
    logic signed [11:0]                 x;
    logic signed [11:0]                 y;
    bit                                 typed;
    status_t                            want;
  } plan_row_t;

  logic                              clk;
  logic                              rst;
  logic                              cfg_we;
  logic [amct_pkg::CFG_INDEX_W-1:0]  cfg_index;
  logic [amct_pkg::CFG_DATA_W-1:0]   cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [1:0]                        mode;
  logic signed [11:0]                touch_x;
  logic signed [11:0]                touch_y;
  logic                              out_valid;
  logic                              out_stall;
  logic [1:0]                        phase;
  logic [7:0]                        seconds_left;
  logic [2:0]                        taps_seen;
  logic                              entered_active;
  logic                              left_active;
  logic                              countdown_cancelled;

  away_mode_arm_and_corner_tap_exit_unit dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .mode                (mode),
    .touch_x             (touch_x),
    .touch_y             (touch_y),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .phase               (phase),
    .seconds_left        (seconds_left),
    .taps_seen           (taps_seen),
    .entered_active      (entered_active),
    .left_active         (left_active),
    .countdown_cancelled (countdown_cancelled)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // predictor state: a private copy of the controller and its registers
  // ---------------------------------------------------------------------------
  regs_t             regs;
  amct_pkg::phase_t  ph;
  logic [7:0]        sec_cnt;
  logic [9:0]        sub_ticks;
  logic [31:0]       ms_clock;
  logic [2:0]        taps;
  logic [31:0]       window_start;

  status_t     status_due[$];   // status words still owed by the block
  plan_row_t   plan[$];
  int          faults = 0;
  int          words_sent;
  bit          in_gaps;         // sender may pause between words
  bit          out_gaps;        // receiver may stall

  function automatic void clear_state();
    regs.corner    = amct_pkg::RST_CORNER_SIZE;
    regs.window    = amct_pkg::RST_TAP_WINDOW;
    regs.taps_exit = amct_pkg::RST_TAPS_TO_EXIT;
    regs.cd_secs   = amct_pkg::RST_COUNTDOWN_SECONDS;
    regs.tps       = amct_pkg::RST_TICKS_PER_SECOND;
    regs.width     = amct_pkg::RST_SCREEN_WIDTH;
    regs.height    = amct_pkg::RST_SCREEN_HEIGHT;
    ph           = amct_pkg::PH_OFF;
    sec_cnt      = '0;
    sub_ticks    = '0;
    ms_clock     = '0;
    taps         = '0;
    window_start = '0;
  endfunction

  function automatic void set_reg(logic [amct_pkg::CFG_INDEX_W-1:0] idx,
                                  logic [amct_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      amct_pkg::CFG_CORNER_SIZE:       regs.corner    = data[11:0];
      amct_pkg::CFG_TAP_WINDOW:        regs.window    = data[15:0];
      amct_pkg::CFG_TAPS_TO_EXIT:      regs.taps_exit = data[2:0];
      amct_pkg::CFG_COUNTDOWN_SECONDS: regs.cd_secs   = data[7:0];
      amct_pkg::CFG_TICKS_PER_SECOND:  regs.tps       = data[9:0];
      amct_pkg::CFG_SCREEN_WIDTH:      regs.width     = data[12:0];
      amct_pkg::CFG_SCREEN_HEIGHT:     regs.height    = data[12:0];
      default: ;
    endcase
  endfunction

  // advance the controller copy by one input word, return the status it yields
  function automatic status_t next_status(amct_pkg::mode_t m, logic signed [11:0] x,
                                          logic signed [11:0] y);
    status_t     s;
    int unsigned per_sec;
    int          c;
    int          cx;
    int          cy;
    bit          hit;
    s = '0;
    case (m)
      amct_pkg::MODE_TICK: begin
        // the millisecond clock runs in every phase
        ms_clock = ms_clock + 32'd1;
        if (ph == amct_pkg::PH_PEND) begin
          per_sec = (regs.tps == 0) ? 1 : regs.tps;
          sub_ticks = sub_ticks + 10'd1;
          if (sub_ticks >= per_sec) begin
            sub_ticks = '0;
            // a count of zero or one ends the countdown on this second
            if (sec_cnt <= 8'd1) begin
              sec_cnt   = '0;
              ph        = amct_pkg::PH_ACT;
              taps      = '0;
              s.entered = 1'b1;
            end else begin
              sec_cnt = sec_cnt - 8'd1;
            end
          end
        end
      end
      amct_pkg::MODE_TOUCH: begin
        if (ph == amct_pkg::PH_ACT) begin
          c  = int'(regs.corner);
          cx = int'(x);
          cy = int'(y);
          hit = (cx < c || cx > int'(regs.width) - c) &&
                (cy < c || cy > int'(regs.height) - c);
          if (hit) begin
            // window age wraps with the clock
            if (taps == 0 || (ms_clock - window_start) > regs.window) begin
              taps         = 3'd1;
              window_start = ms_clock;
            end else begin
              taps = taps + 3'd1;
            end
            if (taps >= regs.taps_exit) begin
              taps       = '0;
              ph         = amct_pkg::PH_OFF;
              s.left_act = 1'b1;
            end
          end
        end
      end
      amct_pkg::MODE_REQ_ON: begin
        if (ph == amct_pkg::PH_OFF) begin
          ph        = amct_pkg::PH_PEND;
          sec_cnt   = regs.cd_secs;
          sub_ticks = '0;
        end
      end
      default: begin
        if (ph == amct_pkg::PH_PEND) begin
          ph          = amct_pkg::PH_OFF;
          s.cancelled = 1'b1;
        end else if (ph == amct_pkg::PH_ACT) begin
          ph         = amct_pkg::PH_OFF;
          s.left_act = 1'b1;
        end
      end
    endcase
    s.ph   = ph;
    s.secs = (ph == amct_pkg::PH_PEND) ? sec_cnt : 8'd0;
    s.taps = taps;
    return s;
  endfunction

  function automatic status_t st(amct_pkg::phase_t p, int secs, int t, bit e, bit l, bit c);
    status_t s;
    s.ph        = p;
    s.secs      = secs[7:0];
    s.taps      = t[2:0];
    s.entered   = e;
    s.left_act  = l;
    s.cancelled = c;
    return s;
  endfunction

  function automatic plan_row_t row_word(amct_pkg::mode_t m, int x, int y,
                                         bit typed = 1'b0, status_t want = '0);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.data   = '0;
    r.m      = m;
    r.x      = x[11:0];
    r.y      = y[11:0];
    r.typed  = typed;
    r.want   = want;
    return r;
  endfunction

  function automatic plan_row_t row_reg(logic [amct_pkg::CFG_INDEX_W-1:0] idx, int data);
    plan_row_t r;
    r        = row_word(amct_pkg::MODE_TICK, 0, 0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data[15:0];
    return r;
  endfunction

  // coordinate on a corner edge or just inside a corner along one axis
  function automatic logic signed [11:0] corner_coord(int span);
    int v;
    int c;
    c = int'(regs.corner);
    if ($urandom_range(0, 4) == 0)
      v = $urandom_range(0, 1) ? c : span - c;
    else if ($urandom_range(0, 1) != 0)
      v = c - 1 - int'($urandom_range(0, 20));
    else
      v = span - c + 1 + int'($urandom_range(0, 20));
    if (v > 2047) v = 2047;
    if (v < -2048) v = -2048;
    return v[11:0];
  endfunction

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_word(amct_pkg::mode_t m, logic signed [11:0] x,
                           logic signed [11:0] y, bit typed, status_t want);
    status_t s;
    cfg_we <= 1'b0;
    // random pause before the word
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    touch_x  <= x;
    touch_y  <= y;
    do @(posedge clk); while (in_stall);
    // accepted at this edge
    s = next_status(m, x, y);
    status_due.push_back(typed ? want : s);
    words_sent++;
  endtask

  // block drained: every owed status has arrived
  task automatic settle();
    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(logic [amct_pkg::CFG_INDEX_W-1:0] idx,
                           logic [amct_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic randomize_regs();
    int r;
    r = $urandom_range(0, 9);
    cfg_write(amct_pkg::CFG_CORNER_SIZE,
              16'((r < 7) ? $urandom_range(0, 200) : $urandom_range(0, 65535)));
    r = $urandom_range(0, 9);
    cfg_write(amct_pkg::CFG_TAP_WINDOW,
              16'((r < 6) ? $urandom_range(0, 30) :
                  (r < 8) ? $urandom_range(0, 3000) : $urandom_range(0, 65535)));
    cfg_write(amct_pkg::CFG_TAPS_TO_EXIT, 16'($urandom_range(0, 7)));
    r = $urandom_range(0, 9);
    cfg_write(amct_pkg::CFG_COUNTDOWN_SECONDS,
              16'((r < 9) ? $urandom_range(0, 4) : $urandom_range(5, 40)));
    r = $urandom_range(0, 19);
    cfg_write(amct_pkg::CFG_TICKS_PER_SECOND,
              16'((r < 19) ? $urandom_range(0, 4) : $urandom_range(0, 65535)));
    r = $urandom_range(0, 9);
    cfg_write(amct_pkg::CFG_SCREEN_WIDTH,
              16'((r < 5) ? $urandom_range(200, 1024) :
                  (r < 7) ? 4096 : $urandom_range(1, 65535)));
    r = $urandom_range(0, 9);
    cfg_write(amct_pkg::CFG_SCREEN_HEIGHT,
              16'((r < 5) ? $urandom_range(200, 1024) :
                  (r < 7) ? 4096 : $urandom_range(1, 65535)));
  endtask

  // pick the next word from the current phase so most traffic is a
  // plausible arm / count down / tap-out sequence; calm keeps a countdown alive
  task automatic pick_word(input bit calm, output amct_pkg::mode_t m,
                           output logic signed [11:0] x, output logic signed [11:0] y);
    int r;
    r = $urandom_range(0, 99);
    x = 12'($urandom_range(0, 4095));
    y = 12'($urandom_range(0, 4095));
    case (ph)
      amct_pkg::PH_OFF:
        m = (r < 70) ? amct_pkg::MODE_REQ_ON : amct_pkg::mode_t'($urandom_range(0, 3));
      amct_pkg::PH_PEND: begin
        if (calm || r < 88) m = amct_pkg::MODE_TICK;
        else if (r < 92)    m = amct_pkg::MODE_REQ_OFF;
        else if (r < 96)    m = amct_pkg::MODE_TOUCH;
        else                m = amct_pkg::MODE_REQ_ON;
      end
      default: begin
        if (r < 60)      m = amct_pkg::MODE_TOUCH;
        else if (r < 93) m = amct_pkg::MODE_TICK;
        else if (r < 97) m = amct_pkg::MODE_REQ_OFF;
        else             m = amct_pkg::MODE_REQ_ON;
      end
    endcase
    // most touches aimed at a corner, on or near its edge
    if (m == amct_pkg::MODE_TOUCH && $urandom_range(0, 3) != 0) begin
      x = corner_coord(regs.width);
      y = corner_coord(regs.height);
    end
  endtask

  task automatic random_words(int n, bit calm);
    amct_pkg::mode_t    m;
    logic signed [11:0] x;
    logic signed [11:0] y;
    repeat (n) begin
      pick_word(calm, m, x, y);
      send_word(m, x, y, 1'b0, '0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: stall bursts of random length in cycles
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_gaps && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each status word with the oldest one owed
  always @(posedge clk) begin
    status_t got;
    status_t exp_s;
    if (!rst && out_valid && !out_stall) begin
      got.ph        = amct_pkg::phase_t'(phase);
      got.secs      = seconds_left;
      got.taps      = taps_seen;
      got.entered   = entered_active;
      got.left_act  = left_active;
      got.cancelled = countdown_cancelled;
      if (status_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: status word with none owed: ph=%0d secs=%0d taps=%0d e=%0b l=%0b c=%0b",
                   $realtime, got.ph, got.secs, got.taps, got.entered, got.left_act,
                   got.cancelled);
      end else begin
        exp_s = status_due.pop_front();
        if (got !== exp_s) begin
          faults++;
          if (faults <= 10) begin
            $display("%0t: mismatch exp ph=%0d secs=%0d taps=%0d e=%0b l=%0b c=%0b",
                     $realtime, exp_s.ph, exp_s.secs, exp_s.taps, exp_s.entered,
                     exp_s.left_act, exp_s.cancelled);
            $display("%0t:          got ph=%0d secs=%0d taps=%0d e=%0b l=%0b c=%0b",
                     $realtime, got.ph, got.secs, got.taps, got.entered, got.left_act,
                     got.cancelled);
          end
        end
      end
    end
  end

  // watchdog on cycles where nothing moves
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet = 0;
    else
      quiet = quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[away_mode_arm_and_corner_tap_exit_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    bit prev_cfg;
    int round_no;
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    mode       = amct_pkg::MODE_TICK;
    touch_x    = '0;
    touch_y    = '0;
    words_sent = 0;
    in_gaps    = 1'b1;
    out_gaps   = 1'b1;
    clear_state();

    // reset defaults: requests, touches and ticks while off / pending
    plan.push_back(row_word(amct_pkg::MODE_REQ_OFF, 0, 0, 1'b1,
                            st(amct_pkg::PH_OFF, 0, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 0, 0, 1'b1,
                            st(amct_pkg::PH_OFF, 0, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0, 1'b1,
                            st(amct_pkg::PH_OFF, 0, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0, 1'b1,
                            st(amct_pkg::PH_PEND, 10, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0, 1'b1,
                            st(amct_pkg::PH_PEND, 10, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0, 1'b1,
                            st(amct_pkg::PH_PEND, 10, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 0, 0, 1'b1,
                            st(amct_pkg::PH_PEND, 10, 0, 1'b0, 1'b0, 1'b0)));
    plan.push_back(row_word(amct_pkg::MODE_REQ_OFF, 0, 0, 1'b1,
                            st(amct_pkg::PH_OFF, 0, 0, 1'b0, 1'b0, 1'b1)));
    // zero countdown and zero ticks per second: active after one tick
    plan.push_back(row_reg(amct_pkg::CFG_COUNTDOWN_SECONDS, 0));
    plan.push_back(row_reg(amct_pkg::CFG_TICKS_PER_SECOND, 0));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 500, 300));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, -2048, -2048));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 2047, 2047));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_REQ_OFF, 0, 0));
    // zero tap target with the widest corner: first tap exits
    plan.push_back(row_reg(amct_pkg::CFG_TAPS_TO_EXIT, 0));
    plan.push_back(row_reg(amct_pkg::CFG_CORNER_SIZE, 4095));
    plan.push_back(row_reg(amct_pkg::CFG_TAP_WINDOW, 0));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 0, 0));
    // zero corner, screen 4096 wide and 1 high, longest window, highest target
    plan.push_back(row_reg(amct_pkg::CFG_TAPS_TO_EXIT, 7));
    plan.push_back(row_reg(amct_pkg::CFG_CORNER_SIZE, 0));
    plan.push_back(row_reg(amct_pkg::CFG_TAP_WINDOW, 65535));
    plan.push_back(row_reg(amct_pkg::CFG_SCREEN_WIDTH, 4096));
    plan.push_back(row_reg(amct_pkg::CFG_SCREEN_HEIGHT, 1));
    plan.push_back(row_reg(amct_pkg::CFG_COUNTDOWN_SECONDS, 2));
    plan.push_back(row_reg(amct_pkg::CFG_TICKS_PER_SECOND, 1));
    plan.push_back(row_word(amct_pkg::MODE_REQ_ON, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TICK, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, 0, 0));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, -1, -1));
    plan.push_back(row_word(amct_pkg::MODE_TOUCH, -1, 2047));
    plan.push_back(row_word(amct_pkg::MODE_REQ_OFF, 0, 0));

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed plan
    prev_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!prev_cfg) settle();
        cfg_write(plan[i].idx, plan[i].data);
      end else begin
        send_word(plan[i].m, plan[i].x, plan[i].y, plan[i].typed, plan[i].want);
      end
      prev_cfg = plan[i].is_cfg;
    end

    // random rounds, each with its own register setting and idling mix
    round_no = 0;
    while (words_sent < 420) begin
      in_gaps  = ($urandom_range(0, 3) != 0);
      out_gaps = ($urandom_range(0, 3) != 0);
      settle();
      randomize_regs();
      if (round_no == 2) begin
        // longest countdown, one tick per second
        cfg_write(amct_pkg::CFG_COUNTDOWN_SECONDS, 16'd255);
        cfg_write(amct_pkg::CFG_TICKS_PER_SECOND, 16'd1);
        random_words(320, 1'b1);
      end else begin
        random_words($urandom_range(30, 90), 1'b0);
      end
      round_no++;
    end

    // last part: no idling, 200 ticks per second
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    settle();
    randomize_regs();
    cfg_write(amct_pkg::CFG_COUNTDOWN_SECONDS, 16'd1);
    cfg_write(amct_pkg::CFG_TICKS_PER_SECOND, 16'd200);
    random_words(260, 1'b1);

    in_valid <= 1'b0;
    while (status_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (faults == 0) begin
      $display("[away_mode_arm_and_corner_tap_exit_unit] OK");
    end else begin
      $display("[away_mode_arm_and_corner_tap_exit_unit] ERROR");
    end
    $finish;
  end

endmodule
